>>> rtl/core/alarm_code_entry_controller_assert.svh
// Assertion macros used by the checker of the alarm controller.
// They expect signals named clk and arst_n in the scope of use.
`ifndef ALARM_CODE_ENTRY_CONTROLLER_ASSERT_SVH
`define ALARM_CODE_ENTRY_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACEC_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACEC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/core/acec_pkg.sv
`default_nettype none

package acec_pkg;

	localparam int TIMER_BITS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int DELAY_W     = 16;
	localparam int THRESH_W    = 10;
	localparam int TRIES_W     = 3;
	localparam int PROG_W      = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int ACTION_W    = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_EXIT_DELAY  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_DELAY = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESH = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRIES   = 4'd3;

	// Reset values of the configuration registers.
	localparam logic [DELAY_W-1:0]  EXIT_DELAY_RST   = 16'd200;
	localparam logic [DELAY_W-1:0]  ENTRY_DELAY_RST  = 16'd100;
	localparam logic [THRESH_W-1:0] LIGHT_THRESH_RST = 10'd10;
	localparam logic [TRIES_W-1:0]  MAX_TRIES_RST    = 3'd3;

	// Event codes.
	localparam logic [ACTION_W-1:0] ACT_PRESS = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LIGHT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

	// Code positions: A at first and third, B at second and fourth.
	localparam logic [PROG_W-1:0] PROG_FIRST = 3'd1;
	localparam logic [PROG_W-1:0] PROG_THIRD = 3'd3;
	localparam logic [PROG_W-1:0] PROG_LAST  = 3'd4;
	localparam logic [PROG_W-1:0] PROG_DONE  = 3'd5;

	localparam logic [TRIES_W-1:0] TRIES_SAT = 3'd7;

endpackage

`default_nettype wire

>>> rtl/core/alarm_code_entry_controller.sv
// Alarm code-entry controller. Events (button press, light sample, timer tick)
// arrive on the input channel and each yields one status transfer on the output
// channel showing the state after the event. The block takes one event per
// clock cycle while the output side does not stall. An event is held in the
// input register and its status is then loaded into the result register,
// from which it is transferred when the output side is ready. A stalled
// output holds the input register, and a new event is taken again in the
// cycle the waiting status is transferred. The state update is a single pass
// of small flag and counter logic between those two registers. The
// configuration port is always ready and must be written only while no event
// is in flight; writes to unknown indexes are dropped.
`default_nettype none

module alarm_code_entry_controller
	import acec_pkg::*;
#(
	parameter int TIMER_BITS  = TIMER_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,

	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ACTION_W-1:0]    action,
	input  wire logic                   pin_a_flag,
	input  wire logic                   pin_b_flag,
	input  wire logic [SAMPLE_BITS-1:0] light_level,

	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        is_armed,
	output logic                        intrusion_seen,
	output logic                        alarm_on,
	output logic                        led_on,
	output logic [PROG_W-1:0]           code_progress,
	output logic [TRIES_W-1:0]          wrong_count
);

	localparam int CMP_BITS = (SAMPLE_BITS < THRESH_W) ? SAMPLE_BITS : THRESH_W;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_EXIT,
		MODE_ENTRY
	} mode_t;

	logic [DELAY_W-1:0]     exit_delay_q;
	logic [DELAY_W-1:0]     entry_delay_q;
	logic [THRESH_W-1:0]    light_thresh_q;
	logic [TRIES_W-1:0]     max_tries_q;

	logic                   valid_s1;
	logic [ACTION_W-1:0]    action_s1;
	logic                   pin_a_s1;
	logic                   pin_b_s1;
	logic [SAMPLE_BITS-1:0] level_s1;

	logic                   out_valid_q;
	logic [PROG_W-1:0]      progress_q, progress_d;
	logic                   armed_q, armed_d;
	logic                   intrusion_q, intrusion_d;
	logic [TRIES_W-1:0]     wrong_q, wrong_d;
	logic                   alarm_q, alarm_d;
	logic                   led_q, led_d;
	logic [TIMER_BITS-1:0]  countdown_q, countdown_d;
	mode_t                  mode_q, mode_d;

	logic                   advance;
	logic                   is_a, is_b, press_ok, in_code;
	logic [TIMER_BITS-1:0]  exit_load, entry_load, count_dec;

	assign cfg_ready = 1'b1;

	// The state registers double as the result register: they change only when
	// a result is loaded.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid      = out_valid_q;
	assign is_armed       = armed_q;
	assign intrusion_seen = intrusion_q;
	assign alarm_on       = alarm_q;
	assign led_on         = led_q;
	assign code_progress  = progress_q;
	assign wrong_count    = wrong_q;

	assign exit_load  = TIMER_BITS'(exit_delay_q);
	assign entry_load = TIMER_BITS'(entry_delay_q);
	assign count_dec  = (countdown_q != '0) ? countdown_q - TIMER_BITS'(1) : countdown_q;

	assign is_a     = pin_a_s1 && !pin_b_s1;
	assign is_b     = pin_b_s1 && !pin_a_s1;
	assign press_ok = (progress_q == PROG_FIRST || progress_q == PROG_THIRD) ? is_a : is_b;
	assign in_code  = (progress_q >= PROG_FIRST) && (progress_q <= PROG_LAST);

	always_comb begin
		progress_d  = progress_q;
		armed_d     = armed_q;
		intrusion_d = intrusion_q;
		wrong_d     = wrong_q;
		alarm_d     = alarm_q;
		led_d       = led_q;
		countdown_d = countdown_q;
		mode_d      = mode_q;
		unique case (action_s1)
			ACT_PRESS: begin
				if (!armed_q) begin
					if (in_code) begin
						if (press_ok) begin
							progress_d = progress_q + PROG_W'(1);
							if (progress_q == PROG_LAST) begin
								countdown_d = exit_load;
								mode_d      = MODE_EXIT;
							end
						end else begin
							progress_d = PROG_FIRST;
						end
					end
				end else if (intrusion_q) begin
					if (in_code) begin
						if (press_ok) begin
							if (progress_q == PROG_LAST) begin
								led_d       = 1'b0;
								armed_d     = 1'b0;
								intrusion_d = 1'b0;
								wrong_d     = '0;
								alarm_d     = 1'b0;
								progress_d  = PROG_FIRST;
								countdown_d = '0;
								mode_d      = MODE_IDLE;
							end else begin
								progress_d = progress_q + PROG_W'(1);
							end
						end else begin
							progress_d = PROG_FIRST;
							if (wrong_q != TRIES_SAT) begin
								wrong_d = wrong_q + TRIES_W'(1);
							end
						end
					end
					// The wrong-try check follows every press seen after an intrusion.
					if (wrong_d > max_tries_q) begin
						alarm_d = 1'b1;
					end
				end
			end
			ACT_LIGHT: begin
				if (armed_q && !intrusion_q &&
				    level_s1[CMP_BITS-1:0] < light_thresh_q[CMP_BITS-1:0]) begin
					led_d       = 1'b1;
					intrusion_d = 1'b1;
					progress_d  = PROG_FIRST;
					countdown_d = entry_load;
					mode_d      = MODE_ENTRY;
				end
			end
			ACT_TICK: begin
				if (mode_q != MODE_IDLE) begin
					countdown_d = count_dec;
					if (count_dec == '0) begin
						if (mode_q == MODE_EXIT) begin
							armed_d = 1'b1;
						end else begin
							alarm_d = 1'b1;
						end
						mode_d = MODE_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_delay_q   <= EXIT_DELAY_RST;
			entry_delay_q  <= ENTRY_DELAY_RST;
			light_thresh_q <= LIGHT_THRESH_RST;
			max_tries_q    <= MAX_TRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXIT_DELAY:   exit_delay_q   <= cfg_data;
				REG_ENTRY_DELAY:  entry_delay_q  <= cfg_data;
				REG_LIGHT_THRESH: light_thresh_q <= cfg_data[THRESH_W-1:0];
				REG_MAX_TRIES:    max_tries_q    <= cfg_data[TRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			pin_a_s1  <= pin_a_flag;
			pin_b_s1  <= pin_b_flag;
			level_s1  <= light_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			progress_q  <= PROG_FIRST;
			armed_q     <= 1'b0;
			intrusion_q <= 1'b0;
			wrong_q     <= '0;
			alarm_q     <= 1'b0;
			led_q       <= 1'b0;
			countdown_q <= '0;
			mode_q      <= MODE_IDLE;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				progress_q  <= progress_d;
				armed_q     <= armed_d;
				intrusion_q <= intrusion_d;
				wrong_q     <= wrong_d;
				alarm_q     <= alarm_d;
				led_q       <= led_d;
				countdown_q <= countdown_d;
				mode_q      <= mode_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/acec_checker.sv
`default_nettype none

`include "alarm_code_entry_controller_assert.svh"

module acec_checker
	import acec_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               is_armed,
	input wire logic               intrusion_seen,
	input wire logic               alarm_on,
	input wire logic               led_on,
	input wire logic [PROG_W-1:0]  code_progress,
	input wire logic [TRIES_W-1:0] wrong_count
);

	// A stalled status transfer keeps its contents.
	`ACEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_armed) && $stable(intrusion_seen) && $stable(alarm_on) && $stable(led_on) && $stable(code_progress) && $stable(wrong_count), "status changed while stalled")

	// The LED is lit exactly from intrusion until disarm.
	`ACEC_ASSERT_IMP(a_led_intrusion, out_valid, led_on == intrusion_seen, "LED and intrusion disagree")

	// Intrusion and alarm only arise while armed, and disarming clears both.
	`ACEC_ASSERT_IMP(a_disarmed_quiet, out_valid && !is_armed, !intrusion_seen && !alarm_on, "intrusion or alarm while disarmed")

	// Progress stays in range, and a finished arming code never coexists with an intrusion.
	`ACEC_ASSERT_IMP(a_progress, out_valid, code_progress >= PROG_FIRST && code_progress <= PROG_DONE && (code_progress != PROG_DONE || !intrusion_seen), "code progress out of range")

endmodule

bind alarm_code_entry_controller acec_checker u_acec_checker (.*);

`default_nettype wire
